>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");

`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");

`else

`define ASSERT_IMPLIES(name, ante, cons)

`define ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> src/ujse_pkg.sv
// ----------------------------------------------------------------------------
// ujse_pkg
// Types, character constants and helper functions of the JSON string escaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ujse_pkg;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_CHAR,
    KIND_ESC,
    KIND_UNIT,
    KIND_PAIR
  } kind_e;

  typedef struct packed {
    logic [2:0]  reps;
    kind_e       kind;
    logic [6:0]  ch;
    logic [15:0] hi;
    logic [15:0] lo;
    logic        fin;
  } cmd_t;

  localparam logic [15:0] ReplUnit    = 16'hfffd;
  localparam logic [20:0] ReplCode    = 21'h00fffd;
  localparam logic [6:0]  ChBackslash = 7'h5c;
  localparam logic [6:0]  ChQuote     = 7'h22;
  localparam logic [6:0]  ChU         = 7'h75;
  localparam logic [6:0]  ChB         = 7'h62;
  localparam logic [6:0]  ChF         = 7'h66;
  localparam logic [6:0]  ChN         = 7'h6e;
  localparam logic [6:0]  ChR         = 7'h72;
  localparam logic [6:0]  ChT         = 7'h74;
  localparam logic [6:0]  ChFill      = 7'h3f;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] val;
    val = {3'b000, nib};
    if (nib < 4'd10) begin
      hex_char = 7'h30 + val;
    end else begin
      hex_char = 7'h57 + val;
    end
  endfunction

  function automatic logic [6:0] unit_char(input logic [15:0] unit, input logic [2:0] pos);
    unique case (pos)
      3'd0: unit_char = ChBackslash;
      3'd1: unit_char = ChU;
      3'd2: unit_char = hex_char(unit[15:12]);
      3'd3: unit_char = hex_char(unit[11:8]);
      3'd4: unit_char = hex_char(unit[7:4]);
      default: unit_char = hex_char(unit[3:0]);
    endcase
  endfunction

endpackage

>>> src/utf8_json_string_escaper_unit.sv
// ----------------------------------------------------------------------------
// utf8_json_string_escaper_unit
// Decodes a UTF-8 byte stream and emits its JSON-escaped text, one printable
// ASCII character per beat.
//
// Input channel: one string byte per beat with final_byte_i on the string's
// last byte. Output channel: one character per beat; run_last_o marks the
// last character caused by an input byte, text_end_o the last character of
// the whole string. A byte that only opens or extends a sequence gives no
// beat.
// Each byte's command is written into the command queue; the expander then
// registers its characters one by one in the output register. The decoder
// takes one byte per cycle unless the queue is full; the expander gives one
// character per cycle unless the receiver stalls, and a byte gives as many
// characters as it expands to: 1 for plain ASCII, 2 for a short escape, 6 for
// \uXXXX, 12 for a surrogate pair and up to 24 when replacements pile up. A
// four-entry command queue sits between decoder and expander.
// When the receiver stalls, the output register holds its beat, the queue
// fills and in_stall_o rises once it is full.
// Reset clears the decoder state, the queue and the output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_json_string_escaper_unit import ujse_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] out_char_o,
  output logic       run_last_o,
  output logic       text_end_o
);

  logic push;
  logic pop;
  logic full;
  logic head_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  ujse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .full_i       (full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  ujse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (push_cmd),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  ujse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o),
    .text_end_o   (text_end_o)
  );

  `ASSERT_IMPLIES(a_no_push_when_full, push, !full)
  `ASSERT_IMPLIES(a_no_pop_when_empty, pop, head_valid)
  `ASSERT_IMPLIES(a_printable_out, out_valid_o, (out_char_o >= 7'h20) && (out_char_o != 7'h7f))
  `ASSERT_IMPLIES(a_end_closes_run, out_valid_o && text_end_o, run_last_o)

endmodule

>>> src/ujse_front.sv
// ----------------------------------------------------------------------------
// ujse_front
// UTF-8 decoder. Takes one byte per beat, tracks open sequences and turns
// each byte into at most one command: a number of replacement escapes and an
// optional classified code point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ujse_front import ujse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  input  logic       full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [1:0]  pend_q, pend_d;
  logic [2:0]  len_q, len_d;
  logic [20:0] part_q, part_d;

  logic        accept;
  logic        is_cont;
  logic [2:0]  n_cnt;
  logic [20:0] cont_code;
  logic [20:0] min_code;
  logic        bad_code;
  logic        lead;
  logic [2:0]  reps;
  logic        has_code;
  logic [20:0] cp;
  logic [19:0] v_off;

  assign accept    = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign is_cont   = in_byte_i[7:6] == 2'b10;
  assign n_cnt     = {1'b0, pend_q} + 3'd1;
  assign cont_code = {part_q[14:0], in_byte_i[5:0]};

  always_comb begin
    if (len_q == 3'd2) begin
      min_code = 21'h000080;
    end else if (len_q == 3'd3) begin
      min_code = 21'h000800;
    end else begin
      min_code = 21'h010000;
    end
  end

  assign bad_code = (cont_code < min_code) || (cont_code > 21'h10ffff) ||
                    ((cont_code >= 21'h00d800) && (cont_code <= 21'h00dfff));

  always_comb begin
    pend_d   = pend_q;
    len_d    = len_q;
    part_d   = part_q;
    reps     = 3'd0;
    has_code = 1'b0;
    cp       = 21'd0;
    lead     = 1'b0;
    if ((pend_q != 2'd0) && is_cont) begin
      if (n_cnt >= len_q) begin
        pend_d = 2'd0;
        len_d  = 3'd0;
        part_d = 21'd0;
        if (bad_code) begin
          reps = n_cnt;
        end else begin
          has_code = 1'b1;
          cp       = cont_code;
        end
      end else if (final_byte_i) begin
        reps   = n_cnt;
        pend_d = 2'd0;
        len_d  = 3'd0;
        part_d = 21'd0;
      end else begin
        pend_d = n_cnt[1:0];
        part_d = cont_code;
      end
    end else begin
      reps   = {1'b0, pend_q};
      pend_d = 2'd0;
      len_d  = 3'd0;
      part_d = 21'd0;
      priority if (!in_byte_i[7]) begin
        has_code = 1'b1;
        cp       = {13'd0, in_byte_i};
      end else if (in_byte_i[7:5] == 3'b110) begin
        lead   = 1'b1;
        len_d  = 3'd2;
        part_d = {16'd0, in_byte_i[4:0]};
      end else if (in_byte_i[7:4] == 4'b1110) begin
        lead   = 1'b1;
        len_d  = 3'd3;
        part_d = {17'd0, in_byte_i[3:0]};
      end else if (in_byte_i[7:3] == 5'b11110) begin
        lead   = 1'b1;
        len_d  = 3'd4;
        part_d = {18'd0, in_byte_i[2:0]};
      end else begin
        has_code = 1'b1;
        cp       = ReplCode;
      end
      if (lead) begin
        if (final_byte_i) begin
          reps   = reps + 3'd1;
          len_d  = 3'd0;
          part_d = 21'd0;
        end else begin
          pend_d = 2'd1;
        end
      end
    end
  end

  assign v_off = 20'(cp - 21'h010000);

  always_comb begin
    cmd_o.reps = reps;
    cmd_o.fin  = final_byte_i;
    cmd_o.kind = KIND_NONE;
    cmd_o.ch   = ChFill;
    cmd_o.hi   = cp[15:0];
    cmd_o.lo   = {6'b110111, v_off[9:0]};
    if (has_code) begin
      unique case (cp)
        21'h000022: begin cmd_o.kind = KIND_ESC; cmd_o.ch = ChQuote; end
        21'h00005c: begin cmd_o.kind = KIND_ESC; cmd_o.ch = ChBackslash; end
        21'h000008: begin cmd_o.kind = KIND_ESC; cmd_o.ch = ChB; end
        21'h00000c: begin cmd_o.kind = KIND_ESC; cmd_o.ch = ChF; end
        21'h00000a: begin cmd_o.kind = KIND_ESC; cmd_o.ch = ChN; end
        21'h00000d: begin cmd_o.kind = KIND_ESC; cmd_o.ch = ChR; end
        21'h000009: begin cmd_o.kind = KIND_ESC; cmd_o.ch = ChT; end
        default: begin
          priority if ((cp >= 21'h000020) && (cp < 21'h00007f)) begin
            cmd_o.kind = KIND_CHAR;
            cmd_o.ch   = cp[6:0];
          end else if (cp <= 21'h00ffff) begin
            cmd_o.kind = KIND_UNIT;
          end else begin
            cmd_o.kind = KIND_PAIR;
            cmd_o.hi   = {6'b110110, v_off[19:10]};
          end
        end
      endcase
    end
  end

  assign push_o = accept && ((reps != 3'd0) || has_code);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      len_q  <= 3'd0;
      part_q <= 21'd0;
    end else if (accept) begin
      pend_q <= pend_d;
      len_q  <= len_d;
      part_q <= part_d;
    end
  end

endmodule

>>> src/ujse_queue.sv
// ----------------------------------------------------------------------------
// ujse_queue
// Small command queue between the decoder and the character expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ujse_queue import ujse_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic head_valid_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = cnt_q == CntW'(Depth);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> src/ujse_back.sv
// ----------------------------------------------------------------------------
// ujse_back
// Character expander. Walks the command at the queue head one output
// character per beat and drives the registered output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ujse_back import ujse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic [6:0] out_char_o,
  output logic       run_last_o,
  output logic       text_end_o
);

  logic [3:0] pos_q, pos_d;
  logic [2:0] rep_idx_q, rep_idx_d;
  logic       out_valid_q;
  logic [6:0] out_char_q;
  logic       run_last_q;
  logic       text_end_q;

  logic       adv;
  logic       fire;
  logic       in_rep;
  logic       rep_wrap;
  logic       last;
  logic [6:0] ch_sel;

  assign adv      = !out_valid_q || !out_stall_i;
  assign fire     = adv && head_valid_i;
  assign in_rep   = rep_idx_q != head_i.reps;
  assign rep_wrap = in_rep && (pos_q == 4'd5);

  always_comb begin
    ch_sel = ChFill;
    last   = 1'b0;
    if (in_rep) begin
      ch_sel = unit_char(ReplUnit, pos_q[2:0]);
      last   = rep_wrap && (rep_idx_q == head_i.reps - 3'd1) && (head_i.kind == KIND_NONE);
    end else begin
      unique case (head_i.kind)
        KIND_CHAR: begin
          ch_sel = head_i.ch;
          last   = 1'b1;
        end
        KIND_ESC: begin
          ch_sel = (pos_q == 4'd0) ? ChBackslash : head_i.ch;
          last   = pos_q == 4'd1;
        end
        KIND_UNIT: begin
          ch_sel = unit_char(head_i.hi, pos_q[2:0]);
          last   = pos_q == 4'd5;
        end
        KIND_PAIR: begin
          if (pos_q < 4'd6) begin
            ch_sel = unit_char(head_i.hi, pos_q[2:0]);
          end else begin
            ch_sel = unit_char(head_i.lo, 3'(pos_q - 4'd6));
          end
          last = pos_q == 4'd11;
        end
        default: begin
          ch_sel = ChFill;
          last   = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    pos_d     = pos_q;
    rep_idx_d = rep_idx_q;
    if (fire) begin
      priority if (last) begin
        pos_d     = 4'd0;
        rep_idx_d = 3'd0;
      end else if (rep_wrap) begin
        pos_d     = 4'd0;
        rep_idx_d = rep_idx_q + 3'd1;
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end
  end

  assign pop_o = fire && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 4'd0;
      rep_idx_q   <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      rep_idx_q <= rep_idx_d;
      if (adv) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_char_q <= ch_sel;
      run_last_q <= last;
      text_end_q <= last && head_i.fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = run_last_q;
  assign text_end_o  = text_end_q;

endmodule
